// ===== rtl/drwm_pkg.sv =====
// Package for the dark-rejecting window mean: payload structs, widths,
// result source codes and the request/response structs of the shared divider.
// No dependencies.
package drwm_pkg;

  localparam int CH_W  = 8;              // one colour channel
  localparam int CNT_W = 5;              // kept-pixel count
  localparam int SUM_W = CH_W + CNT_W;   // per-channel sum of up to 31 pixels
  localparam int THR_W = 10;             // dark threshold, spans 0..765
  localparam int KIND_W = 2;

  localparam int WINDOW_RADIUS_DEF = 2;
  localparam int COUNT_MAX = 31;

  localparam logic [THR_W-1:0] DARK_RESET = 10'd120;
  localparam logic [CH_W-1:0]  WHITE      = 8'hFF;

  // Result source codes
  localparam logic [KIND_W-1:0] KIND_MEAN   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CENTER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WHITE  = 2'd2;

  typedef struct packed {
    logic [CH_W-1:0] blue_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] red_in;
    logic            inside_req;
    logic            is_center;
    logic            last;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]   red_out;
    logic [CH_W-1:0]   green_out;
    logic [CH_W-1:0]   blue_out;
    logic [CNT_W-1:0]  kept_count;
    logic [KIND_W-1:0] source_kind;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [CH_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/drwm_div.sv =====
// Shared restoring divider: one quotient bit per cycle, eight steps.
// Depends on drwm_pkg. Expects dividend <= 255 * divisor, divisor != 0.
module drwm_div
  import drwm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t div_req,
  output div_rsp_t div_rsp
);

  localparam int STEP_W = $clog2(CH_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CH_W - 1);

  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  dvsr_r, dvsr_nxt;
  logic [CH_W-1:0]   quo_r, quo_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W:0]    trial;
  logic [CNT_W+1:0]  diff;

  assign trial = {rem_r, quo_r[CH_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvsr_r};

  always_comb begin
    rem_nxt  = rem_r;
    dvsr_nxt = dvsr_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (div_req.start) begin
      // Upper bits are below the divisor since the mean fits a byte
      rem_nxt  = div_req.dividend[SUM_W-1:CH_W];
      quo_nxt  = div_req.dividend[CH_W-1:0];
      dvsr_nxt = div_req.divisor;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[CNT_W+1]) begin
        rem_nxt = diff[CNT_W-1:0];
        quo_nxt = {quo_r[CH_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[CNT_W-1:0];
        quo_nxt = {quo_r[CH_W-2:0], 1'b0};
      end
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
  end

  assign div_rsp.busy     = busy_r;
  assign div_rsp.done     = done_r;
  assign div_rsp.quotient = quo_r;

endmodule

// ===== rtl/dark_rejecting_window_mean.sv =====
// Dark-rejecting window mean: averages the non-dark pixels of one window.
// Non-last pixels: one request per cycle, accumulated in the accept cycle.
// Last pixel with a mean: three passes of the shared divider (blue, green,
// red) in S_DIV, then S_PUSH loads the result register; fallback: straight to S_PUSH.
// Input is held off while a window result forms and until it is loaded into a free result register.
// Reset (rst_n, synchronous): threshold 120, sums/count/center cleared, no result.
module dark_rejecting_window_mean
  import drwm_pkg::*;
#(
  parameter int WINDOW_RADIUS = WINDOW_RADIUS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [THR_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  // Window size, capped so the count and sums never wrap
  localparam int WINDOW_SIDE   = 2 * WINDOW_RADIUS + 1;
  localparam int WINDOW_PIXELS = WINDOW_SIDE * WINDOW_SIDE;
  localparam int KEEP_LIMIT_I  = (WINDOW_PIXELS < COUNT_MAX) ? WINDOW_PIXELS : COUNT_MAX;
  localparam logic [CNT_W-1:0] KEEP_LIMIT = CNT_W'(KEEP_LIMIT_I);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_PUSH} state_t;
  typedef enum logic [1:0] {CH_BLUE, CH_GREEN, CH_RED} chan_t;

  state_t            state_r, state_nxt;
  chan_t             chan_r, chan_nxt;
  logic [THR_W-1:0]  thr_r, thr_nxt;
  logic [SUM_W-1:0]  sum_blue_r, sum_blue_nxt;
  logic [SUM_W-1:0]  sum_green_r, sum_green_nxt;
  logic [SUM_W-1:0]  sum_red_r, sum_red_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CH_W-1:0]   ctr_blue_r, ctr_blue_nxt;
  logic [CH_W-1:0]   ctr_green_r, ctr_green_nxt;
  logic [CH_W-1:0]   ctr_red_r, ctr_red_nxt;
  logic              ctr_seen_r, ctr_seen_nxt;
  logic [CH_W-1:0]   mean_blue_r, mean_blue_nxt;
  logic [CH_W-1:0]   mean_green_r, mean_green_nxt;
  logic [CH_W-1:0]   mean_red_r, mean_red_nxt;
  logic              div_start_r, div_start_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic [THR_W-1:0]  pix_sum;
  logic              keep;
  logic              accept;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // Shared divider, reused for the three channels in turn
  drwm_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  always_comb begin
    div_req.start   = div_start_r;
    div_req.divisor = count_r;
    unique case (chan_r)
      CH_BLUE:  div_req.dividend = sum_blue_r;
      CH_GREEN: div_req.dividend = sum_green_r;
      default:  div_req.dividend = sum_red_r;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Brightness test: B+G+R fits the threshold width (max 765)
  assign pix_sum = THR_W'(in_data.blue_in) + THR_W'(in_data.green_in)
                 + THR_W'(in_data.red_in);
  assign keep    = in_data.inside_req && (pix_sum > thr_r) && (count_r < KEEP_LIMIT);

  always_comb begin
    state_nxt      = state_r;
    chan_nxt       = chan_r;
    thr_nxt        = thr_r;
    sum_blue_nxt   = sum_blue_r;
    sum_green_nxt  = sum_green_r;
    sum_red_nxt    = sum_red_r;
    count_nxt      = count_r;
    ctr_blue_nxt   = ctr_blue_r;
    ctr_green_nxt  = ctr_green_r;
    ctr_red_nxt    = ctr_red_r;
    ctr_seen_nxt   = ctr_seen_r;
    mean_blue_nxt  = mean_blue_r;
    mean_green_nxt = mean_green_r;
    mean_red_nxt   = mean_red_r;
    div_start_nxt  = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;

    if (cfg_wr_en) begin
      thr_nxt = cfg_wr_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          // Latest inside center wins
          if (in_data.inside_req && in_data.is_center) begin
            ctr_blue_nxt  = in_data.blue_in;
            ctr_green_nxt = in_data.green_in;
            ctr_red_nxt   = in_data.red_in;
            ctr_seen_nxt  = 1'b1;
          end
          if (keep) begin
            sum_blue_nxt  = sum_blue_r + SUM_W'(in_data.blue_in);
            sum_green_nxt = sum_green_r + SUM_W'(in_data.green_in);
            sum_red_nxt   = sum_red_r + SUM_W'(in_data.red_in);
            count_nxt     = count_r + CNT_W'(1);
          end
          // Last pixel is already folded in before the result forms
          if (in_data.last) begin
            if (ctr_seen_nxt && (count_nxt != '0)) begin
              state_nxt     = S_DIV;
              chan_nxt      = CH_BLUE;
              div_start_nxt = 1'b1;
            end else begin
              state_nxt = S_PUSH;
            end
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          unique case (chan_r)
            CH_BLUE:  mean_blue_nxt  = div_rsp.quotient;
            CH_GREEN: mean_green_nxt = div_rsp.quotient;
            default:  mean_red_nxt   = div_rsp.quotient;
          endcase
          if (chan_r == CH_RED) begin
            state_nxt = S_PUSH;
          end else begin
            chan_nxt      = chan_t'(chan_r + 2'd1);
            div_start_nxt = 1'b1;
          end
        end
      end
      S_PUSH: begin
        // Hold until the result register is free, then load and clear the window
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          priority if (!ctr_seen_r) begin
            out_data_nxt.red_out     = WHITE;
            out_data_nxt.green_out   = WHITE;
            out_data_nxt.blue_out    = WHITE;
            out_data_nxt.kept_count  = '0;
            out_data_nxt.source_kind = KIND_WHITE;
          end else if (count_r != '0) begin
            out_data_nxt.red_out     = mean_red_r;
            out_data_nxt.green_out   = mean_green_r;
            out_data_nxt.blue_out    = mean_blue_r;
            out_data_nxt.kept_count  = count_r;
            out_data_nxt.source_kind = KIND_MEAN;
          end else begin
            out_data_nxt.red_out     = ctr_red_r;
            out_data_nxt.green_out   = ctr_green_r;
            out_data_nxt.blue_out    = ctr_blue_r;
            out_data_nxt.kept_count  = '0;
            out_data_nxt.source_kind = KIND_CENTER;
          end
          sum_blue_nxt  = '0;
          sum_green_nxt = '0;
          sum_red_nxt   = '0;
          count_nxt     = '0;
          ctr_seen_nxt  = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chan_r      <= CH_BLUE;
      thr_r       <= DARK_RESET;
      sum_blue_r  <= '0;
      sum_green_r <= '0;
      sum_red_r   <= '0;
      count_r     <= '0;
      ctr_seen_r  <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chan_r      <= chan_nxt;
      thr_r       <= thr_nxt;
      sum_blue_r  <= sum_blue_nxt;
      sum_green_r <= sum_green_nxt;
      sum_red_r   <= sum_red_nxt;
      count_r     <= count_nxt;
      ctr_seen_r  <= ctr_seen_nxt;
      div_start_r <= div_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ctr_blue_r   <= ctr_blue_nxt;
    ctr_green_r  <= ctr_green_nxt;
    ctr_red_r    <= ctr_red_nxt;
    mean_blue_r  <= mean_blue_nxt;
    mean_green_r <= mean_green_nxt;
    mean_red_r   <= mean_red_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Input stays closed while the divider works on a window
  a_no_accept_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.busy |-> !in_ready)
    else $error("request taken while divider busy");

  // Kept count never passes the window limit
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= KEEP_LIMIT)
    else $error("kept count above window limit");

  // A mean result always carries a nonzero count, fallbacks carry zero
  a_mean_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.source_kind == KIND_MEAN) |-> out_data_r.kept_count != '0)
    else $error("mean result with zero count");

  a_fallback_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.source_kind != KIND_MEAN) |-> out_data_r.kept_count == '0)
    else $error("fallback result with nonzero count");

endmodule
